// ===== design/kmsd_pkg.sv =====
// Shared types and constants for the keypad matrix scanner.
// Holds scan and key phase codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package kmsd_pkg;

    typedef enum logic [3:0] {
        PH_INIT     = 4'b0001,
        PH_ROW_LOW  = 4'b0010,
        PH_CHECK    = 4'b0100,
        PH_ROW_HIGH = 4'b1000
    } scan_phase_t;

    typedef enum logic [3:0] {
        KEY_IDLE       = 4'b0001,
        KEY_PRESS_DB   = 4'b0010,
        KEY_PRESSED    = 4'b0100,
        KEY_RELEASE_DB = 4'b1000
    } key_phase_t;

    typedef enum logic [3:0] {
        CTL_IDLE   = 4'b0001,
        CTL_READ   = 4'b0010,
        CTL_UPDATE = 4'b0100,
        CTL_FINISH = 4'b1000
    } ctl_state_t;

    typedef struct packed {
        key_phase_t  phase;
        logic [15:0] start;
        logic        evt;
        logic        released;
    } key_upd_t;

    localparam logic [2:0] CFG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] CFG_SETTLE      = 3'd1;
    localparam logic [2:0] CFG_NC_MASK     = 3'd2;
    localparam logic [2:0] CFG_PRESS_MASK  = 3'd3;
    localparam logic [2:0] CFG_RELEASE_MASK = 3'd4;

    localparam logic [14:0] DEBOUNCE_RESET = 15'd20;
    localparam logic [14:0] SETTLE_RESET   = 15'd2;

endpackage

`default_nettype wire

// ===== design/keypad_matrix_scan_debounce.sv =====
// Keypad matrix scanner: one scan step per input word, one row phase per step.
// A step that does not sample columns gives its single result word, registered, in
// the cycle after acceptance. A sampling step (settle time reached) walks the row's
// keys through the single-port key state memory, a read state and an update state
// per column plus a closing state; an update that must push out a held event, and
// the closing state, wait while the result side stalls. Events come in rising column
// order, the last word of a step carries tlast. Depends on kmsd_pkg and kmsd_key_update.
`default_nettype none

module keypad_matrix_scan_debounce #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // tick, column_levels[3:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // row_drive[3:0], event_row[1:0], event_column[1:0]
    output logic [1:0]  m_tuser,    // event_valid, event_released
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import kmsd_pkg::*;

    localparam int KEYS   = ROWS * COLUMNS;
    localparam int KEY_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int MEM_W  = 20;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    // configuration
    logic [14:0] debounce_reg;
    logic [14:0] settle_reg;
    logic [15:0] nc_mask_reg;
    logic [15:0] press_mask_reg;
    logic [15:0] release_mask_reg;

    // scan state
    scan_phase_t      scan_phase_reg, scan_phase_next;
    logic [ROW_W-1:0] current_row_reg, current_row_next;
    logic [15:0]      tick_count_reg, tick_count_next;
    logic [15:0]      settle_start_reg, settle_start_next;
    logic [3:0]       row_levels_reg, row_levels_next;
    logic [3:0]       levels_reg;

    // column walk
    ctl_state_t       ctl_reg, ctl_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [1:0]       pend_col_reg, pend_col_next;
    logic             pend_rel_reg, pend_rel_next;

    // key state memory
    logic [MEM_W-1:0] key_mem [KEYS];
    logic [MEM_W-1:0] rd_data_reg;
    logic [KEY_W-1:0] addr_reg;
    logic [KEY_W-1:0] rd_addr;
    logic [KEYS-1:0]  valid_reg;
    logic             rd_en;
    logic             wr_en;

    // output word
    logic             out_load;
    logic [3:0]       out_drive;
    logic             out_evt;
    logic [1:0]       out_col;
    logic             out_rel;
    logic             out_last;
    logic             out_free;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic [1:0]       m_tuser_reg;
    logic             m_tlast_reg;

    logic             s_acc;
    logic [15:0]      tick_inc;
    logic [15:0]      settle_age;
    logic             settle_done;
    logic             start_cols;
    logic [1:0]       row_lo;
    logic             key_level;
    logic             key_nc;
    logic             key_press_rep;
    logic             key_release_rep;
    key_phase_t       phase_rd;
    key_upd_t         upd;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (ctl_reg == CTL_IDLE) && out_free;
    assign s_acc     = s_tvalid && s_tready;

    assign tick_inc    = tick_count_reg + 16'(s_tdata[0]);
    assign settle_age  = tick_inc - settle_start_reg;
    assign settle_done = (settle_age >= {1'b0, settle_reg});
    assign row_lo      = 2'(current_row_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg     <= DEBOUNCE_RESET;
            settle_reg       <= SETTLE_RESET;
            nc_mask_reg      <= '0;
            press_mask_reg   <= '0;
            release_mask_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DEBOUNCE:     debounce_reg     <= cfg_data[14:0];
                CFG_SETTLE:       settle_reg       <= cfg_data[14:0];
                CFG_NC_MASK:      nc_mask_reg      <= cfg_data;
                CFG_PRESS_MASK:   press_mask_reg   <= cfg_data;
                CFG_RELEASE_MASK: release_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        scan_phase_next   = scan_phase_reg;
        current_row_next  = current_row_reg;
        tick_count_next   = tick_count_reg;
        settle_start_next = settle_start_reg;
        row_levels_next   = row_levels_reg;
        start_cols        = 1'b0;
        if (s_acc) begin
            tick_count_next = tick_inc;
            case (scan_phase_reg)
                PH_INIT: begin
                    row_levels_next  = 4'hF;
                    current_row_next = '0;
                    scan_phase_next  = PH_ROW_LOW;
                end
                PH_ROW_LOW: begin
                    row_levels_next   = row_levels_reg & ~(4'b0001 << row_lo);
                    settle_start_next = tick_inc;
                    scan_phase_next   = PH_CHECK;
                end
                PH_CHECK: begin
                    if (settle_done) begin
                        start_cols      = 1'b1;
                        scan_phase_next = PH_ROW_HIGH;
                    end
                end
                default: begin
                    row_levels_next  = row_levels_reg | (4'b0001 << row_lo);
                    current_row_next = (current_row_reg == ROW_LAST) ? '0
                                     : current_row_reg + 1'b1;
                    scan_phase_next  = PH_ROW_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_phase_reg   <= PH_INIT;
            current_row_reg  <= '0;
            tick_count_reg   <= '0;
            settle_start_reg <= '0;
            row_levels_reg   <= 4'hF;
        end else begin
            scan_phase_reg   <= scan_phase_next;
            current_row_reg  <= current_row_next;
            tick_count_reg   <= tick_count_next;
            settle_start_reg <= settle_start_next;
            row_levels_reg   <= row_levels_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            levels_reg <= s_tdata[4:1];
        end
    end

    // key lookup for the column under work
    assign rd_addr  = KEY_W'(int'(current_row_reg) * COLUMNS + int'(col_reg));
    assign phase_rd = valid_reg[addr_reg] ? key_phase_t'(rd_data_reg[19:16]) : KEY_IDLE;
    assign key_level       = (int'(col_reg) < 4) ? levels_reg[2'(col_reg)] : 1'b0;
    assign key_nc          = (int'(addr_reg) < 16) ? nc_mask_reg[4'(addr_reg)] : 1'b0;
    assign key_press_rep   = (int'(addr_reg) < 16) ? press_mask_reg[4'(addr_reg)] : 1'b0;
    assign key_release_rep = (int'(addr_reg) < 16) ? release_mask_reg[4'(addr_reg)] : 1'b0;

    kmsd_key_update u_key_update (
        .phase_in       (phase_rd),
        .start_in       (rd_data_reg[15:0]),
        .level          (key_level),
        .nc_bit         (key_nc),
        .press_rep      (key_press_rep),
        .release_rep    (key_release_rep),
        .tick_count     (tick_count_reg),
        .debounce_ticks (debounce_reg),
        .upd            (upd)
    );

    always_comb begin
        ctl_next        = ctl_reg;
        col_next        = col_reg;
        pend_valid_next = pend_valid_reg;
        pend_col_next   = pend_col_reg;
        pend_rel_next   = pend_rel_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        out_load        = 1'b0;
        out_drive       = row_levels_reg;
        out_evt         = 1'b0;
        out_col         = 2'd0;
        out_rel         = 1'b0;
        out_last        = 1'b1;
        case (ctl_reg)
            CTL_IDLE: begin
                if (s_acc) begin
                    if (start_cols) begin
                        col_next = '0;
                        ctl_next = CTL_READ;
                    end else begin
                        out_load  = 1'b1;
                        out_drive = row_levels_next;
                    end
                end
            end
            CTL_READ: begin
                rd_en    = 1'b1;
                ctl_next = CTL_UPDATE;
            end
            CTL_UPDATE: begin
                // a new event pushes the held one out, wait if the output is busy
                if (!(upd.evt && pend_valid_reg && !out_free)) begin
                    wr_en = 1'b1;
                    if (upd.evt) begin
                        if (pend_valid_reg) begin
                            out_load = 1'b1;
                            out_evt  = 1'b1;
                            out_col  = pend_col_reg;
                            out_rel  = pend_rel_reg;
                            out_last = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_col_next   = 2'(col_reg);
                        pend_rel_next   = upd.released;
                    end
                    if (col_reg == COL_LAST) begin
                        ctl_next = CTL_FINISH;
                    end else begin
                        col_next = col_reg + 1'b1;
                        ctl_next = CTL_READ;
                    end
                end
            end
            CTL_FINISH: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_evt         = pend_valid_reg;
                    out_col         = pend_valid_reg ? pend_col_reg : 2'd0;
                    out_rel         = pend_valid_reg && pend_rel_reg;
                    pend_valid_next = 1'b0;
                    ctl_next        = CTL_IDLE;
                end
            end
            default: begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg        <= CTL_IDLE;
            col_reg        <= '0;
            pend_valid_reg <= 1'b0;
            valid_reg      <= '0;
        end else begin
            ctl_reg        <= ctl_next;
            col_reg        <= col_next;
            pend_valid_reg <= pend_valid_next;
            if (wr_en) begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_col_reg <= pend_col_next;
        pend_rel_reg <= pend_rel_next;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= key_mem[rd_addr];
            addr_reg    <= rd_addr;
        end
        if (wr_en) begin
            key_mem[addr_reg] <= {upd.phase, upd.start};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {out_col, (out_evt ? row_lo : 2'd0), out_drive};
            m_tuser_reg <= {out_rel, out_evt};
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_one_row_low: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(~row_levels_reg) <= 1)
        else $error("more than one row driven low");

    a_no_event_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("word without event is not last");

    a_pending_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> ctl_reg != CTL_IDLE)
        else $error("held event left behind after step");

    a_sample_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && start_cols |=> ctl_reg == CTL_READ && col_reg == '0)
        else $error("column walk did not start");

endmodule

`default_nettype wire

// ===== design/kmsd_key_update.sv =====
// Debounce step for one key: next phase, start time and event.
// Depends on kmsd_pkg.
`default_nettype none

module kmsd_key_update (
    input  kmsd_pkg::key_phase_t phase_in,
    input  logic [15:0]          start_in,
    input  logic                 level,
    input  logic                 nc_bit,
    input  logic                 press_rep,
    input  logic                 release_rep,
    input  logic [15:0]          tick_count,
    input  logic [14:0]          debounce_ticks,
    output kmsd_pkg::key_upd_t   upd
);
    import kmsd_pkg::*;

    logic pressed;
    logic elapsed;
    logic [15:0] age;

    assign pressed = (level == nc_bit);
    assign age     = tick_count - start_in;
    assign elapsed = (age >= {1'b0, debounce_ticks});

    always_comb begin
        upd.phase    = phase_in;
        upd.start    = start_in;
        upd.evt      = 1'b0;
        upd.released = 1'b0;
        case (phase_in)
            KEY_IDLE: begin
                if (pressed) begin
                    upd.start = tick_count;
                    upd.phase = KEY_PRESS_DB;
                end
            end
            KEY_PRESS_DB: begin
                if (!pressed) begin
                    upd.phase = KEY_IDLE;
                end else if (elapsed) begin
                    upd.phase = KEY_PRESSED;
                    upd.evt   = press_rep;
                end
            end
            KEY_PRESSED: begin
                if (!pressed) begin
                    upd.start = tick_count;
                    upd.phase = KEY_RELEASE_DB;
                end
            end
            default: begin
                if (pressed) begin
                    upd.phase = KEY_PRESSED;
                end else if (elapsed) begin
                    upd.phase    = KEY_IDLE;
                    upd.evt      = release_rep;
                    upd.released = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire
